@@ hw/rtl/sstr_pkg.sv @@
package sstr_pkg;

   localparam int PULSES_PER_SPAN_DEF = 2;

   localparam int CMD_W      = 3;
   localparam int TS_W       = 32;
   localparam int TGT_W      = 13;
   localparam int THR_W      = 11;
   localparam int SPD_W      = 16;
   localparam int MODE_W     = 2;
   localparam int DLY_W      = 16;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam int DIV_NUM_W = 26;
   localparam int DIV_DEN_W = 32;

   localparam logic [CMD_W-1:0] CMD_TACH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HALT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EXPIRE = 3'd4;

   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

   localparam logic [1:0] OP_SPEED = 2'd0;
   localparam logic [1:0] OP_ERR   = 2'd1;
   localparam logic [1:0] OP_SPD   = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   localparam logic [THR_W-1:0] THR_MIN = 11'd48;

   typedef struct packed {
      logic       load_in;
      logic       div_start;
      logic [1:0] op_sel;
      logic       save_a;
      logic       commit;
   } sstr_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [MODE_W-1:0] mode;
      logic              span_end;
      logic              run_big;
      logic              tgt_zero;
   } sstr_status_type;

endpackage

@@ hw/rtl/spin_speed_throttle_ramp.sv @@
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: command; tdata: timestamp_us, target_speed
// rsp      out        rsp_tvalid/rsp_tready  tdata: throttle, speed, mode, delay, rejected
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction at a time; each division runs on the shared restoring divider (one
// quotient bit per cycle). Span-end tach pulses and smooth stop ticks with a nonzero
// target take one division, run ticks with an error above 100 two; others take none.
// Synchronous active-high reset restores the register defaults and idle mode.
// A stalled result holds in the output register; the next result waits until it is taken.
module spin_speed_throttle_ramp #(
   parameter int PULSES_PER_SPAN = sstr_pkg::PULSES_PER_SPAN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] timestamp_us, [44:32] target_speed, [47:45] zero
   input  logic [sstr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] command
   input  logic [sstr_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [10:0] throttle_out, [26:11] speed_out, [28:27] mode_out,
   // [44:29] next_delay_ms, [45] rejected, [47:46] zero
   output logic [sstr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sstr_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [sstr_pkg::CFG_DATA_W-1:0]   csr_data
);

   sstr_pkg::sstr_cmd_type    ctl;
   sstr_pkg::sstr_status_type sts;
   logic                      div_done;

   assign csr_ready = 1'b1;

   sstr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .div_done   (div_done),
      .ctl        (ctl)
   );

   sstr_dpath #(
      .PULSES_PER_SPAN (PULSES_PER_SPAN)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .div_done  (div_done),
      .req_cmd   (req_tuser),
      .req_ts    (req_tdata[31:0]),
      .req_tgt   (req_tdata[44:32]),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_tdata)
   );

endmodule

@@ hw/rtl/sstr_div.sv @@
module sstr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sstr_pkg::DIV_NUM_W-1:0]  num,
   input  logic [sstr_pkg::DIV_DEN_W-1:0]  den,
   output logic [sstr_pkg::DIV_NUM_W-1:0]  quot,
   output logic                            done
);

   localparam int NumW = sstr_pkg::DIV_NUM_W;
   localparam int DenW = sstr_pkg::DIV_DEN_W;
   localparam int CntW = $clog2(NumW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumW-1:0] qr_ff, qr_in;
   logic [DenW-1:0] rem_ff, rem_in;
   logic [DenW-1:0] den_ff, den_in;

   logic [DenW:0]   trial;
   logic [DenW:0]   trial_sub;
   logic            ge;

   always_comb begin
      trial     = {rem_ff, qr_ff[NumW-1]};
      ge        = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qr_in   = qr_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(NumW);
         qr_in   = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         qr_in  = {qr_ff[NumW-2:0], ge};
         rem_in = ge ? trial_sub[DenW-1:0] : trial[DenW-1:0];
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = qr_ff;
   assign done = done_ff;

endmodule

@@ hw/rtl/sstr_ctrl.sv @@
module sstr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  sstr_pkg::sstr_status_type sts,
   input  logic                      div_done,
   output sstr_pkg::sstr_cmd_type    ctl
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PLAN   = 3'd1;
   localparam logic [2:0] ST_DIV1   = 3'd2;
   localparam logic [2:0] ST_DIV2   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       run_tick, stop_tick, tach_end, out_free;

   always_comb begin
      run_tick  = (sts.cmd == sstr_pkg::CMD_TICK) && (sts.mode == sstr_pkg::MODE_RUN);
      stop_tick = (sts.cmd == sstr_pkg::CMD_TICK) && (sts.mode == sstr_pkg::MODE_STOP);
      tach_end  = (sts.cmd == sstr_pkg::CMD_TACH) && sts.span_end;
      out_free  = !rsp_valid_ff || rsp_tready;

      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load_in = 1'b1;
               state_in    = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (tach_end) begin
               ctl.div_start = 1'b1;
               ctl.op_sel    = sstr_pkg::OP_SPEED;
               state_in      = ST_DIV1;
            end else if (run_tick && sts.run_big) begin
               ctl.div_start = 1'b1;
               ctl.op_sel    = sstr_pkg::OP_ERR;
               state_in      = ST_DIV1;
            end else if (stop_tick && !sts.tgt_zero) begin
               ctl.div_start = 1'b1;
               ctl.op_sel    = sstr_pkg::OP_STOP;
               state_in      = ST_DIV1;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               if (run_tick) begin
                  ctl.save_a    = 1'b1;
                  ctl.div_start = 1'b1;
                  ctl.op_sel    = sstr_pkg::OP_SPD;
                  state_in      = ST_DIV2;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hw/rtl/sstr_dpath.sv @@
module sstr_dpath #(
   parameter int PULSES_PER_SPAN = sstr_pkg::PULSES_PER_SPAN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sstr_pkg::sstr_cmd_type            ctl,
   output sstr_pkg::sstr_status_type         sts,
   output logic                              div_done,
   input  logic [sstr_pkg::CMD_W-1:0]        req_cmd,
   input  logic [sstr_pkg::TS_W-1:0]         req_ts,
   input  logic [sstr_pkg::TGT_W-1:0]        req_tgt,
   input  logic                              csr_we,
   input  logic [sstr_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [sstr_pkg::CFG_DATA_W-1:0]   csr_data,
   output logic [sstr_pkg::RSP_DATA_W-1:0]   rsp_data
);

   localparam int PcW  = $clog2(PULSES_PER_SPAN + 1);
   localparam int NumW = sstr_pkg::DIV_NUM_W;
   localparam int DenW = sstr_pkg::DIV_DEN_W;
   localparam int ThrW = sstr_pkg::THR_W;
   localparam int SpdW = sstr_pkg::SPD_W;
   localparam int TgtW = sstr_pkg::TGT_W;
   localparam int DlyW = sstr_pkg::DLY_W;
   localparam int ModW = sstr_pkg::MODE_W;

   localparam logic [sstr_pkg::CFG_IDX_W-1:0] CFG_SPEEDUP   = 2'd0;
   localparam logic [sstr_pkg::CFG_IDX_W-1:0] CFG_SLOWDOWN  = 2'd1;
   localparam logic [sstr_pkg::CFG_IDX_W-1:0] CFG_START_THR = 2'd2;

   localparam logic [NumW-1:0] SPEED_NUM  = 26'd60000000;
   localparam logic [SpdW-1:0] SPEED_MAX  = 16'hFFFF;
   localparam logic [TgtW-1:0] TGT_MAX    = 13'd6000;
   localparam logic [DlyW-1:0] IDLE_DELAY = 16'd1000;
   localparam logic [ThrW-1:0] THR_MAX    = 11'd2047;

   function automatic logic [ThrW-1:0] clamp_thr(input logic signed [28:0] v);
      logic [ThrW-1:0] r;
      if (v < $signed({18'd0, sstr_pkg::THR_MIN})) begin
         r = sstr_pkg::THR_MIN;
      end else if (v > $signed({18'd0, THR_MAX})) begin
         r = THR_MAX;
      end else begin
         r = v[ThrW-1:0];
      end
      return r;
   endfunction

   logic [sstr_pkg::CMD_W-1:0] cmd_ff;
   logic [sstr_pkg::TS_W-1:0]  ts_ff;
   logic [TgtW-1:0]            tgt_req_ff;
   logic [NumW-1:0]            quot_a_ff;
   logic [sstr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DlyW-1:0] speedup_ff, speedup_in;
   logic [DlyW-1:0] slowdown_ff, slowdown_in;
   logic [ThrW-1:0] start_thr_ff, start_thr_in;

   logic [PcW-1:0]            pc_ff, pc_in;
   logic [sstr_pkg::TS_W-1:0] start_ts_ff, start_ts_in;
   logic [SpdW-1:0]           speed_ff, speed_in;
   logic [TgtW-1:0]           target_ff, target_in;
   logic [ModW-1:0]           mode_ff, mode_in;
   logic [ThrW-1:0]           thr_ff, thr_in;

   logic signed [17:0] diff, sdiff, err_s, stop_lim;
   logic [17:0]        err_wide, smag_wide;
   logic [SpdW-1:0]    err, stop_mag;
   logic               dir_up, stop_neg, run_big, err_mid, span_end;
   logic [DenW-1:0]    span;
   logic [NumW-1:0]    div_num, quot;
   logic [DenW-1:0]    div_den;
   logic [NumW:0]      step;
   logic signed [28:0] thr_s, step_s, quot_s, thr_new;
   logic [DlyW-1:0]    delay;
   logic               rej;

   sstr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      diff     = $signed({5'd0, target_ff}) - $signed({2'd0, speed_ff});
      err_wide = diff[17] ? 18'(-diff) : 18'(diff);
      err      = err_wide[SpdW-1:0];
      dir_up   = !diff[17] && (diff != 18'sd0);
      run_big  = (err > 16'd100) && (target_ff != '0);
      err_mid  = err > 16'd10;

      sdiff     = $signed({5'd0, target_ff}) - $signed({2'd0, err});
      stop_neg  = sdiff[17];
      smag_wide = stop_neg ? 18'(-sdiff) : 18'(sdiff);
      stop_mag  = smag_wide[SpdW-1:0];
      err_s     = $signed({2'd0, err});
      stop_lim  = $signed({5'd0, target_ff}) - 18'sd250;

      span     = ts_ff - start_ts_ff;
      span_end = (pc_ff != '0) && !(pc_ff < PcW'(PULSES_PER_SPAN));

      div_den = {{(DenW-TgtW){1'b0}}, target_ff};
      case (ctl.op_sel)
         sstr_pkg::OP_SPEED: begin
            div_num = SPEED_NUM;
            div_den = span;
         end
         sstr_pkg::OP_ERR:  div_num = {{(NumW-SpdW){1'b0}}, err} * 26'd50;
         sstr_pkg::OP_SPD:  div_num = {{(NumW-SpdW){1'b0}}, speed_ff} * 26'd10;
         sstr_pkg::OP_STOP: div_num = {{(NumW-SpdW){1'b0}}, stop_mag} * 26'd50;
         default:           div_num = '0;
      endcase

      sts.cmd      = cmd_ff;
      sts.mode     = mode_ff;
      sts.span_end = span_end;
      sts.run_big  = run_big;
      sts.tgt_zero = (target_ff == '0);
   end

   always_comb begin
      step    = {1'b0, quot_a_ff} + {1'b0, quot};
      thr_s   = $signed({18'd0, thr_ff});
      step_s  = $signed({2'd0, step});
      quot_s  = stop_neg ? -$signed({3'd0, quot}) : $signed({3'd0, quot});
      thr_new = thr_s;

      pc_in       = pc_ff;
      start_ts_in = start_ts_ff;
      speed_in    = speed_ff;
      target_in   = target_ff;
      mode_in     = mode_ff;
      thr_in      = thr_ff;
      delay       = '0;
      rej         = 1'b0;

      case (cmd_ff)
         sstr_pkg::CMD_TACH: begin
            if (pc_ff == '0) begin
               start_ts_in = ts_ff;
               pc_in       = PcW'(1);
            end else if (!span_end) begin
               pc_in = pc_ff + PcW'(1);
            end else begin
               speed_in = (quot > NumW'(SPEED_MAX)) ? SPEED_MAX : quot[SpdW-1:0];
               pc_in    = '0;
            end
         end
         sstr_pkg::CMD_TICK: begin
            case (mode_ff)
               sstr_pkg::MODE_RUN: begin
                  delay = speedup_ff;
                  if (run_big) begin
                     thr_new = dir_up ? thr_s + step_s : thr_s - step_s;
                  end else if (err_mid) begin
                     thr_new = dir_up ? thr_s + 29'sd1 : thr_s - 29'sd1;
                  end
                  thr_in = clamp_thr(thr_new);
               end
               sstr_pkg::MODE_STOP: begin
                  delay   = slowdown_ff;
                  thr_new = thr_s - quot_s;
                  if (target_ff == '0 || err_s > stop_lim
                      || thr_new < $signed({18'd0, sstr_pkg::THR_MIN})) begin
                     thr_in  = sstr_pkg::THR_MIN;
                     mode_in = sstr_pkg::MODE_IDLE;
                  end else begin
                     thr_in = clamp_thr(thr_new);
                  end
               end
               default: begin
                  delay = IDLE_DELAY;
               end
            endcase
         end
         sstr_pkg::CMD_START: begin
            if (tgt_req_ff == '0 || tgt_req_ff > TGT_MAX) begin
               rej = 1'b1;
            end else begin
               target_in = tgt_req_ff;
               thr_in    = clamp_thr($signed({18'd0, start_thr_ff}));
               mode_in   = sstr_pkg::MODE_RUN;
            end
         end
         sstr_pkg::CMD_HALT: begin
            thr_in  = sstr_pkg::THR_MIN;
            mode_in = sstr_pkg::MODE_STOP;
         end
         sstr_pkg::CMD_EXPIRE: begin
            mode_in = sstr_pkg::MODE_STOP;
         end
         default: begin
         end
      endcase

      rsp_data_in = {2'b00, rej, delay, mode_in, speed_in, thr_in};

      speedup_in   = speedup_ff;
      slowdown_in  = slowdown_ff;
      start_thr_in = start_thr_ff;
      if (csr_we) begin
         case (csr_index)
            CFG_SPEEDUP:   speedup_in   = csr_data;
            CFG_SLOWDOWN:  slowdown_in  = csr_data;
            CFG_START_THR: start_thr_in = csr_data[ThrW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speedup_ff   <= 16'd300;
         slowdown_ff  <= 16'd300;
         start_thr_ff <= 11'd100;
         pc_ff        <= '0;
         start_ts_ff  <= '0;
         speed_ff     <= '0;
         target_ff    <= '0;
         mode_ff      <= sstr_pkg::MODE_IDLE;
         thr_ff       <= sstr_pkg::THR_MIN;
      end else begin
         speedup_ff   <= speedup_in;
         slowdown_ff  <= slowdown_in;
         start_thr_ff <= start_thr_in;
         if (ctl.commit) begin
            pc_ff       <= pc_in;
            start_ts_ff <= start_ts_in;
            speed_ff    <= speed_in;
            target_ff   <= target_in;
            mode_ff     <= mode_in;
            thr_ff      <= thr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         cmd_ff     <= req_cmd;
         ts_ff      <= req_ts;
         tgt_req_ff <= req_tgt;
      end
      if (ctl.save_a) begin
         quot_a_ff <= quot;
      end
      if (ctl.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

@@ hw/rtl/sstr_checker.sv @@
module sstr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [sstr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [sstr_pkg::CMD_W-1:0]        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sstr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [sstr_pkg::CFG_IDX_W-1:0]    csr_index,
   input logic [sstr_pkg::CFG_DATA_W-1:0]   csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_thr_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:0] >= sstr_pkg::THR_MIN)
      else $error("throttle below floor");

   a_idle_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28:27] == sstr_pkg::MODE_IDLE
      |-> rsp_tdata[10:0] == sstr_pkg::THR_MIN)
      else $error("idle mode with throttle above floor");

   a_reject_no_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[45] |-> rsp_tdata[44:29] == 16'd0
      && rsp_tdata[28:27] != 2'd3)
      else $error("rejected start reported a delay");

endmodule

bind spin_speed_throttle_ramp sstr_checker u_checker (.*);
